// File: sv/huv_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// huv_pkg
// Shared types, limits and character codes for the https URL checker.
// ----------------------------------------------------------------------------
package huv_pkg;

   // Limits
   localparam int MAX_URL_BYTES  = 256;   // 16 .. 4096
   localparam int MAX_HOST_BYTES = 253;   // 4 .. 253

   localparam int BYTE_CNT_W = $clog2(MAX_URL_BYTES + 2);
   localparam int HOST_CNT_W = $clog2(MAX_HOST_BYTES + 2);
   localparam int LABEL_W    = 7;         // saturates at 64
   localparam int PORT_W     = 17;        // saturates at 65536
   localparam int PORT_OUT_W = 16;
   localparam int HLEN_W     = 8;
   localparam int PREFIX_LEN = 8;

   localparam logic [BYTE_CNT_W-1:0] URL_LIMIT    = BYTE_CNT_W'(MAX_URL_BYTES);
   localparam logic [BYTE_CNT_W-1:0] PREFIX_LAST  = BYTE_CNT_W'(PREFIX_LEN - 1);
   localparam logic [BYTE_CNT_W-1:0] PREFIX_END   = BYTE_CNT_W'(PREFIX_LEN);
   localparam logic [HOST_CNT_W-1:0] HOST_LIMIT   = HOST_CNT_W'(MAX_HOST_BYTES);
   localparam logic [LABEL_W-1:0]    LABEL_MAX    = LABEL_W'(63);
   localparam logic [LABEL_W-1:0]    LABEL_SAT    = LABEL_W'(64);
   localparam logic [PORT_W-1:0]     PORT_MAX     = PORT_W'(65535);
   localparam logic [PORT_W-1:0]     PORT_SAT     = PORT_W'(65536);

   // Character codes
   localparam logic [7:0] CH_SLASH = 8'h2f;
   localparam logic [7:0] CH_QUERY = 8'h3f;
   localparam logic [7:0] CH_HASH  = 8'h23;
   localparam logic [7:0] CH_AT    = 8'h40;
   localparam logic [7:0] CH_COLON = 8'h3a;
   localparam logic [7:0] CH_DOT   = 8'h2e;
   localparam logic [7:0] CH_DASH  = 8'h2d;
   localparam logic [7:0] CH_UNDER = 8'h5f;
   localparam logic [7:0] CH_TILDE = 8'h7e;
   localparam logic [7:0] CH_ZERO  = 8'h30;

   typedef enum logic [1:0] {
      PH_PREFIX = 2'd0,
      PH_AUTH   = 2'd1,
      PH_PATH   = 2'd2
   } huv_phase_type;

   typedef enum logic [2:0] {
      ST_OK        = 3'd0,
      ST_TOO_LONG  = 3'd1,
      ST_NOT_HTTPS = 3'd2,
      ST_CREDS     = 3'd3,
      ST_BAD_HOST  = 3'd4,
      ST_BAD_PORT  = 3'd5,
      ST_BAD_PATH  = 3'd6
   } huv_status_type;

   typedef struct packed {
      logic [BYTE_CNT_W-1:0] byte_count;
      huv_phase_type         phase;
      logic                  prefix_ok;
      logic [HOST_CNT_W-1:0] host_count;
      logic [LABEL_W-1:0]    label_count;
      logic [7:0]            previous_char;
      logic                  hf_alpha;
      logic                  hf_dot;
      logic                  hf_bad;
      logic [1:0]            colon_count;
      logic [PORT_W-1:0]     port_value;
      logic                  port_digits;
      logic                  ef_at;
      logic                  ef_port_char;
      logic                  ef_path;
      logic                  ef_empty_auth;
   } huv_state_type;

   typedef struct packed {
      huv_status_type        status;
      logic [PORT_OUT_W-1:0] port_number;
      logic [HLEN_W-1:0]     host_bytes;
   } huv_result_type;

   localparam huv_state_type STATE_RESET = '{
      byte_count:    '0,
      phase:         PH_PREFIX,
      prefix_ok:     1'b1,
      host_count:    '0,
      label_count:   '0,
      previous_char: '0,
      hf_alpha:      1'b0,
      hf_dot:        1'b0,
      hf_bad:        1'b0,
      colon_count:   '0,
      port_value:    '0,
      port_digits:   1'b0,
      ef_at:         1'b0,
      ef_port_char:  1'b0,
      ef_path:       1'b0,
      ef_empty_auth: 1'b0
   };

   function automatic logic [7:0] scheme_char(input logic [2:0] idx);
      logic [7:0] ch;
      case (idx)
         3'd0:    ch = 8'h68;   // h
         3'd1:    ch = 8'h74;   // t
         3'd2:    ch = 8'h74;   // t
         3'd3:    ch = 8'h70;   // p
         3'd4:    ch = 8'h73;   // s
         3'd5:    ch = 8'h3a;   // :
         3'd6:    ch = 8'h2f;   // /
         default: ch = 8'h2f;   // /
      endcase
      return ch;
   endfunction

   function automatic logic is_lower(input logic [7:0] c);
      return (c >= 8'h61) && (c <= 8'h7a);
   endfunction

   function automatic logic is_upper(input logic [7:0] c);
      return (c >= 8'h41) && (c <= 8'h5a);
   endfunction

   function automatic logic is_digit(input logic [7:0] c);
      return (c >= 8'h30) && (c <= 8'h39);
   endfunction

endpackage

// File: sv/huv_step.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// huv_step
// Per-word state update and end-of-URL verdict, all combinational.
// ----------------------------------------------------------------------------
module huv_step (
   input  huv_pkg::huv_state_type  cur_state,
   input  logic [7:0]              url_byte,
   input  logic                    is_last,
   output huv_pkg::huv_state_type  next_state,
   output huv_pkg::huv_result_type result
);

   huv_pkg::huv_state_type n;
   logic [huv_pkg::BYTE_CNT_W-1:0] pos;
   logic [huv_pkg::PORT_W+3:0]     port_prod;
   logic                           host_good;
   logic                           term;
   logic                           path_byte;
   logic                           host_char;

   always_comb begin
      n   = cur_state;
      pos = cur_state.byte_count;

      term = (url_byte == huv_pkg::CH_SLASH) || (url_byte == huv_pkg::CH_QUERY) ||
             (url_byte == huv_pkg::CH_HASH);
      host_char = huv_pkg::is_lower(url_byte) || huv_pkg::is_digit(url_byte) ||
                  (url_byte == huv_pkg::CH_DASH) || (url_byte == huv_pkg::CH_DOT);
      path_byte = huv_pkg::is_lower(url_byte) || huv_pkg::is_upper(url_byte) ||
                  huv_pkg::is_digit(url_byte) || (url_byte == huv_pkg::CH_SLASH) ||
                  (url_byte == huv_pkg::CH_DASH) || (url_byte == huv_pkg::CH_UNDER) ||
                  (url_byte == huv_pkg::CH_DOT) || (url_byte == huv_pkg::CH_TILDE);
      // value*10 + digit
      port_prod = ({4'b0, cur_state.port_value} << 3) + ({4'b0, cur_state.port_value} << 1)
                + (huv_pkg::PORT_W + 4)'(url_byte - huv_pkg::CH_ZERO);

      if (cur_state.byte_count <= huv_pkg::URL_LIMIT) begin
         n.byte_count = cur_state.byte_count + 1'b1;
      end

      case (cur_state.phase)
         huv_pkg::PH_PREFIX: begin
            if ((pos < huv_pkg::PREFIX_END) && (huv_pkg::scheme_char(pos[2:0]) != url_byte)) begin
               n.prefix_ok = 1'b0;
            end
            if (pos >= huv_pkg::PREFIX_LAST) begin
               n.phase = huv_pkg::PH_AUTH;
            end
         end
         huv_pkg::PH_AUTH: begin
            if (term) begin
               if (pos == huv_pkg::PREFIX_END) n.ef_empty_auth = 1'b1;
               if (url_byte != huv_pkg::CH_SLASH) n.ef_path = 1'b1;
               n.phase = huv_pkg::PH_PATH;
            end else begin
               if (url_byte == huv_pkg::CH_AT) n.ef_at = 1'b1;
               if (url_byte == huv_pkg::CH_COLON) begin
                  if (cur_state.colon_count < 2'd2) n.colon_count = cur_state.colon_count + 2'd1;
               end else if (cur_state.colon_count == 2'd0) begin
                  // host byte
                  if (cur_state.host_count <= huv_pkg::HOST_LIMIT) begin
                     n.host_count = cur_state.host_count + 1'b1;
                  end
                  if (!host_char) begin
                     n.hf_bad = 1'b1;
                  end else if (url_byte == huv_pkg::CH_DOT) begin
                     if ((cur_state.label_count == '0) ||
                         (cur_state.label_count > huv_pkg::LABEL_MAX) ||
                         (cur_state.previous_char == huv_pkg::CH_DASH)) begin
                        n.hf_bad = 1'b1;
                     end
                     n.label_count = '0;
                     n.hf_dot      = 1'b1;
                  end else begin
                     if ((cur_state.label_count == '0) && (url_byte == huv_pkg::CH_DASH)) begin
                        n.hf_bad = 1'b1;
                     end
                     if (cur_state.label_count < huv_pkg::LABEL_SAT) begin
                        n.label_count = cur_state.label_count + 1'b1;
                     end
                     if (huv_pkg::is_lower(url_byte)) n.hf_alpha = 1'b1;
                  end
                  n.previous_char = url_byte;
               end else if (cur_state.colon_count == 2'd1) begin
                  // port byte
                  if (!huv_pkg::is_digit(url_byte)) begin
                     n.ef_port_char = 1'b1;
                  end else begin
                     n.port_digits = 1'b1;
                     if (port_prod > (huv_pkg::PORT_W + 4)'(huv_pkg::PORT_MAX)) begin
                        n.port_value = huv_pkg::PORT_SAT;
                     end else begin
                        n.port_value = port_prod[huv_pkg::PORT_W-1:0];
                     end
                  end
               end
            end
         end
         default: begin
            if (!path_byte) n.ef_path = 1'b1;
         end
      endcase

      host_good = !n.hf_bad && n.hf_alpha && n.hf_dot && (n.label_count != '0) &&
                  (n.label_count <= huv_pkg::LABEL_MAX) &&
                  (n.previous_char != huv_pkg::CH_DASH) &&
                  (n.host_count != '0) && (n.host_count <= huv_pkg::HOST_LIMIT);

      result.port_number = '0;
      result.host_bytes  = '0;
      if (n.byte_count > huv_pkg::URL_LIMIT) begin
         result.status = huv_pkg::ST_TOO_LONG;
      end else if ((n.byte_count <= huv_pkg::PREFIX_END) || !n.prefix_ok) begin
         result.status = huv_pkg::ST_NOT_HTTPS;
      end else if ((n.phase != huv_pkg::PH_PATH) || n.ef_empty_auth) begin
         result.status = huv_pkg::ST_BAD_PATH;
      end else if (n.ef_at) begin
         result.status = huv_pkg::ST_CREDS;
      end else if ((n.colon_count >= 2'd2) || !host_good) begin
         result.status = huv_pkg::ST_BAD_HOST;
      end else if ((n.colon_count == 2'd1) &&
                   (!n.port_digits || n.ef_port_char ||
                    (n.port_value > huv_pkg::PORT_MAX) || (n.port_value == '0))) begin
         result.status = huv_pkg::ST_BAD_PORT;
      end else if (n.ef_path) begin
         result.status = huv_pkg::ST_BAD_PATH;
      end else begin
         result.status = huv_pkg::ST_OK;
         if (n.colon_count == 2'd1) begin
            result.port_number = n.port_value[huv_pkg::PORT_OUT_W-1:0];
         end
         result.host_bytes = huv_pkg::HLEN_W'(n.host_count);
      end

      // last word closes the URL and rearms for the next one
      next_state = is_last ? huv_pkg::STATE_RESET : n;
   end

endmodule

// File: sv/https_url_validator_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// https_url_validator_core
// Streaming https URL checker: one URL byte per word, one verdict per URL.
// ----------------------------------------------------------------------------
// Flow: a word is registered at the input, then stepped into the parse
//   state; the verdict of a last word goes into the result register as
//   that word leaves the input register.
// Throughput: 1 word per cycle; a last word waits only while a held verdict
//   is not being taken.
// Reset: synchronous, active high; clears both valid bits and puts the parse
//   state at the start of a URL. No clearing pass.
// ----------------------------------------------------------------------------
module https_url_validator_core (
   input  logic        clock,
   input  logic        reset,
   // input words
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_url_byte,
   input  logic        req_is_last,
   // verdicts
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [2:0]  rsp_status,
   output logic [15:0] rsp_port_number,
   output logic [7:0]  rsp_host_bytes
);

   // Input register
   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_byte_ff;
   logic       in_last_ff;

   // Parse state, carried across the words of one URL
   huv_pkg::huv_state_type st_ff, st_in;

   // Result register
   logic                    rsp_valid_ff, rsp_valid_in;
   huv_pkg::huv_result_type rsp_ff;

   huv_pkg::huv_result_type step_result;
   logic                    out_free;
   logic                    advance;

   huv_step u_step (
      .cur_state  (st_ff),
      .url_byte   (in_byte_ff),
      .is_last    (in_last_ff),
      .next_state (st_in),
      .result     (step_result)
   );

   // A non-last word always moves on; a last word waits only while a
   // previous verdict is still held and not being taken.
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign advance   = in_valid_ff && (!in_last_ff || out_free);
   assign req_ready = !in_valid_ff || advance;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_ready) in_valid_in = req_valid;

      rsp_valid_in = rsp_valid_ff;
      if (advance && in_last_ff) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         st_ff        <= huv_pkg::STATE_RESET;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (advance) st_ff <= st_in;
      end
   end

   // Payload registers, no reset
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_byte_ff <= req_url_byte;
         in_last_ff <= req_is_last;
      end
      if (advance && in_last_ff) rsp_ff <= step_result;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_ff.status;
   assign rsp_port_number = rsp_ff.port_number;
   assign rsp_host_bytes  = rsp_ff.host_bytes;

endmodule
